// ===== rtl/fht_pkg.sv =====
// Shared types and constants for the file handle table.
// Holds field widths, request and status codes, and the controller/datapath structs.
// No dependencies.
package fht_pkg;

  localparam int KIND_W   = 3;
  localparam int HANDLE_W = 32;
  localparam int BYTE_W   = 8;
  localparam int VER_W    = 32;
  localparam int PATH_W   = 64;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 5;

  typedef enum logic [KIND_W-1:0] {
    OP_ALLOC     = 3'd0,
    OP_LOOKUP    = 3'd1,
    OP_CLONE     = 3'd2,
    OP_FREE      = 3'd3,
    OP_FREE_ALL  = 3'd4,
    OP_NEXT_PATH = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_t;

  // Source of the data written to the table and echoed in the response.
  typedef enum logic [1:0] {
    SEL_NONE  = 2'd0,
    SEL_INPUT = 2'd1,
    SEL_HIT   = 2'd2,
    SEL_PATH  = 2'd3
  } data_sel_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_DRAIN = 2'd2,
    S_EXEC  = 2'd3
  } state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] entry_kind;
    logic [BYTE_W-1:0] qid_kind;
    logic [VER_W-1:0]  qid_version;
    logic [PATH_W-1:0] qid_path;
  } data_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    data_t               data;
  } entry_t;

  typedef struct packed {
    logic      take;
    logic      scan;
    logic      commit;
    status_t   status;
    data_sel_t sel;
    logic      slot_free;
    logic      wr_en;
    logic      clr_hit;
    logic      clr_all;
    logic      path_bump;
  } cmd_t;

  typedef struct packed {
    logic              req_valid;
    logic              req_scan;
    logic [KIND_W-1:0] op;
    logic              hit_a;
    logic              hit_b;
    logic              free_found;
    logic              scan_last;
    logic              out_free;
  } sts_t;

endpackage

// ===== rtl/fht_req_if.sv =====
// Request channel of the file handle table: valid/ready plus the request fields.
// Depends on fht_pkg for field widths.
interface fht_req_if;
  import fht_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [HANDLE_W-1:0] handle;
  logic [HANDLE_W-1:0] new_handle;
  logic [BYTE_W-1:0]   entry_kind;
  logic [BYTE_W-1:0]   qid_kind;
  logic [VER_W-1:0]    qid_version;
  logic [PATH_W-1:0]   qid_path;

  modport source (
    output valid, kind, handle, new_handle, entry_kind, qid_kind, qid_version, qid_path,
    input  ready
  );

  modport sink (
    input  valid, kind, handle, new_handle, entry_kind, qid_kind, qid_version, qid_path,
    output ready
  );
endinterface

// ===== rtl/fht_rsp_if.sv =====
// Response channel of the file handle table: valid/ready plus the response fields.
// Depends on fht_pkg for field widths.
interface fht_rsp_if;
  import fht_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [BYTE_W-1:0]   out_entry_kind;
  logic [BYTE_W-1:0]   out_qid_kind;
  logic [VER_W-1:0]    out_qid_version;
  logic [PATH_W-1:0]   out_qid_path;

  modport source (
    output valid, status, slot, out_entry_kind, out_qid_kind, out_qid_version, out_qid_path,
    input  ready
  );

  modport sink (
    input  valid, status, slot, out_entry_kind, out_qid_kind, out_qid_version, out_qid_path,
    output ready
  );
endinterface

// ===== rtl/file_handle_table_core.sv =====
// File handle table: TABLE_SLOTS entries searched by a scan of one slot per cycle.
// Allocate, lookup, clone and free scan every slot of the entry memory before they
// respond; a new request is taken only after the last one has loaded its response.
// Free all, next path and unused kinds skip the scan. Reset (synchronous, active high)
// clears all valid marks and sets the path counter to 1; the entry memory is not
// cleared and needs no clearing pass.
module file_handle_table_core #(
  parameter int TABLE_SLOTS = 32
) (
  input logic       clk,
  input logic       rst,
  fht_req_if.sink   req,
  fht_rsp_if.source rsp
);
  import fht_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fht_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  fht_dp #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cmd (cmd),
    .sts (sts)
  );

endmodule

// ===== rtl/fht_ctrl.sv =====
// Controller of the file handle table: sequences the slot scan and decides each request.
// Depends on fht_pkg for the state, command and status types.
module fht_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  fht_pkg::sts_t sts,
  output fht_pkg::cmd_t cmd
);
  import fht_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.take = 1'b1;
        if (sts.req_valid) begin
          state_next = sts.req_scan ? S_SCAN : S_EXEC;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The last slot read is compared during this cycle.
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          cmd.status = ST_OK;
          state_next = S_IDLE;
          case (sts.op)
            OP_ALLOC: begin
              if (sts.hit_a) begin
                cmd.status = ST_DUP;
              end else if (!sts.free_found) begin
                cmd.status = ST_FULL;
              end else begin
                cmd.wr_en     = 1'b1;
                cmd.sel       = SEL_INPUT;
                cmd.slot_free = 1'b1;
              end
            end
            OP_LOOKUP: begin
              if (sts.hit_a) begin
                cmd.sel = SEL_HIT;
              end else begin
                cmd.status = ST_MISS;
              end
            end
            OP_CLONE: begin
              if (!sts.hit_a) begin
                cmd.status = ST_MISS;
              end else if (sts.hit_b) begin
                cmd.status = ST_DUP;
              end else if (!sts.free_found) begin
                cmd.status = ST_FULL;
              end else begin
                cmd.wr_en     = 1'b1;
                cmd.sel       = SEL_HIT;
                cmd.slot_free = 1'b1;
              end
            end
            OP_FREE: begin
              if (sts.hit_a) begin
                cmd.sel     = SEL_HIT;
                cmd.clr_hit = 1'b1;
              end else begin
                cmd.status = ST_MISS;
              end
            end
            OP_FREE_ALL: begin
              cmd.clr_all = 1'b1;
            end
            OP_NEXT_PATH: begin
              cmd.sel       = SEL_PATH;
              cmd.path_bump = 1'b1;
            end
            default: begin
              cmd.status = ST_MISS;
            end
          endcase
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/fht_dp.sv =====
// Datapath of the file handle table: entry memory, valid marks, scan compare,
// path counter and response register. Depends on fht_pkg and both channel interfaces.
module fht_dp #(
  parameter int TABLE_SLOTS = 32
) (
  input  logic          clk,
  input  logic          rst,
  fht_req_if.sink       req,
  fht_rsp_if.source     rsp,
  input  fht_pkg::cmd_t cmd,
  output fht_pkg::sts_t sts
);
  import fht_pkg::*;

  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  logic                   load;
  logic [KIND_W-1:0]      op;
  entry_t                 req_q;
  logic [HANDLE_W-1:0]    key_b;

  logic [TABLE_SLOTS-1:0] valid;
  entry_t                 mem [TABLE_SLOTS];
  entry_t                 rd_q;

  logic [IDX_W-1:0]       scan_idx;
  logic [IDX_W-1:0]       cmp_idx;
  logic                   cmp_en;
  logic                   hit_a;
  logic                   hit_b;
  logic                   free_found;
  logic [IDX_W-1:0]       hit_idx;
  logic [IDX_W-1:0]       free_idx;
  entry_t                 hit_q;

  logic [PATH_W-1:0]      path_ctr;

  entry_t                 wr_entry;
  data_t                  res_data;
  logic [SLOT_W-1:0]      res_slot;

  logic                   out_valid;
  logic [STATUS_W-1:0]    out_status;
  logic [SLOT_W-1:0]      out_slot;
  data_t                  out_data;

  assign load      = cmd.take && req.valid;
  assign req.ready = cmd.take;

  always_ff @(posedge clk) begin
    if (load) begin
      op                       <= req.kind;
      req_q.handle             <= req.handle;
      req_q.data.entry_kind    <= req.entry_kind;
      req_q.data.qid_kind      <= req.qid_kind;
      req_q.data.qid_version   <= req.qid_version;
      req_q.data.qid_path      <= req.qid_path;
      key_b                    <= req.new_handle;
    end
  end

  // Entry memory: one write port at the free slot, one registered read port for the scan.
  assign wr_entry = (cmd.sel == SEL_HIT) ? {key_b, hit_q.data} : req_q;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[free_idx] <= wr_entry;
    end
    if (cmd.scan) begin
      rd_q <= mem[scan_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.clr_all) begin
      valid <= '0;
    end else begin
      if (cmd.wr_en) begin
        valid[free_idx] <= 1'b1;
      end
      if (cmd.clr_hit) begin
        valid[hit_idx] <= 1'b0;
      end
    end
  end

  // Scan: a slot is read into rd_q and compared in the next cycle, against both handle keys.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      cmp_en     <= 1'b0;
      hit_a      <= 1'b0;
      hit_b      <= 1'b0;
      free_found <= 1'b0;
    end else if (load) begin
      scan_idx   <= '0;
      cmp_en     <= 1'b0;
      hit_a      <= 1'b0;
      hit_b      <= 1'b0;
      free_found <= 1'b0;
    end else begin
      cmp_en <= cmd.scan;
      if (cmd.scan) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (cmp_en) begin
        if (valid[cmp_idx] && rd_q.handle == req_q.handle && !hit_a) begin
          hit_a <= 1'b1;
        end
        if (valid[cmp_idx] && rd_q.handle == key_b) begin
          hit_b <= 1'b1;
        end
        if (!valid[cmp_idx] && !free_found) begin
          free_found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx;
    if (cmp_en && valid[cmp_idx] && rd_q.handle == req_q.handle && !hit_a) begin
      hit_idx <= cmp_idx;
      hit_q   <= rd_q;
    end
    if (cmp_en && !valid[cmp_idx] && !free_found) begin
      free_idx <= cmp_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      path_ctr <= PATH_W'(1);
    end else if (cmd.path_bump) begin
      path_ctr <= path_ctr + 1'b1;
    end
  end

  always_comb begin
    res_data = '0;
    case (cmd.sel)
      SEL_INPUT: res_data = req_q.data;
      SEL_HIT:   res_data = hit_q.data;
      SEL_PATH:  res_data.qid_path = path_ctr;
      default:   res_data = '0;
    endcase
  end

  always_comb begin
    if (cmd.sel == SEL_INPUT || cmd.sel == SEL_HIT) begin
      res_slot = cmd.slot_free ? SLOT_W'(free_idx) : SLOT_W'(hit_idx);
    end else begin
      res_slot = '0;
    end
  end

  // The response register lets a new request in while the last response waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status <= cmd.status;
      out_slot   <= res_slot;
      out_data   <= res_data;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_status;
  assign rsp.slot            = out_slot;
  assign rsp.out_entry_kind  = out_data.entry_kind;
  assign rsp.out_qid_kind    = out_data.qid_kind;
  assign rsp.out_qid_version = out_data.qid_version;
  assign rsp.out_qid_path    = out_data.qid_path;

  always_comb begin
    sts            = '0;
    sts.req_valid  = req.valid;
    sts.req_scan   = (req.kind == OP_ALLOC) || (req.kind == OP_LOOKUP) ||
                     (req.kind == OP_CLONE) || (req.kind == OP_FREE);
    sts.op         = op;
    sts.hit_a      = hit_a;
    sts.hit_b      = hit_b;
    sts.free_found = free_found;
    sts.scan_last  = (scan_idx == IDX_W'(TABLE_SLOTS - 1));
    sts.out_free   = !out_valid || rsp.ready;
  end

  a_write_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> !valid[free_idx])
    else $error("write targets a slot that is already in use");

  a_free_all_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_all |=> valid == '0)
    else $error("valid marks remain after free all");

  a_path_step: assert property (@(posedge clk) disable iff (rst)
    cmd.path_bump |=> path_ctr == $past(path_ctr) + 64'd1)
    else $error("path counter did not advance by one");

  a_commit_room: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> sts.out_free)
    else $error("response loaded over an untaken response");

  a_free_hit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_hit |-> hit_a && valid[hit_idx])
    else $error("free clears a slot that did not match");

endmodule
